/* rtl/dcc_pkg.sv */
// package: shared types, codes and constants of the dcc waveform generator
`timescale 1ns / 1ps

package dcc_pkg;

  // message store depth default and count width (covers depths up to 16)
  localparam int MSG_BYTES_DEF = 8;
  localparam int CNT_W = 5;

  // register reset values
  localparam logic [7:0] PREAMBLE_RST = 8'd14;
  localparam logic [7:0] LONG_RST = 8'd27;
  localparam logic [7:0] SHORT_RST = 8'h8D;
  localparam logic [7:0] FIRST_MASK = 8'h80;

  // input opcodes
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_BYTE = 2'd1,
    OP_HEADER = 2'd2,
    OP_NONE = 2'd3
  } opcode_t;

  // register indexes on the apb port (paddr[3:2])
  typedef enum logic [1:0] {
    REG_PREAMBLE = 2'd0,
    REG_LONG = 2'd1,
    REG_SHORT = 2'd2,
    REG_NONE = 2'd3
  } reg_idx_t;

  // bit sequencer phases
  typedef enum logic [3:0] {
    MODE_PRE = 4'b0001,
    MODE_EXT = 4'b0010,
    MODE_SEP = 4'b0100,
    MODE_BITS = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       msg_ready;
    logic [2:0] byte_index;
    logic [7:0] byte_value;
    logic [3:0] msg_length;
    logic [7:0] msg_preamble;
  } in_item_t;

  typedef struct packed {
    logic       pin_level;
    logic [7:0] reload_value;
    logic       bit_is_one;
    logic       asked_message;
  } out_item_t;

  typedef struct packed {
    logic [7:0] preamble_length;
    logic [7:0] long_reload;
    logic [7:0] short_reload;
    logic       preamble_wr;
    logic [7:0] preamble_wdata;
  } cfg_t;

  typedef struct packed {
    logic       tick;
    logic       msg_ready;
    logic       header_wr;
    logic [3:0] msg_length;
    logic [7:0] msg_preamble;
  } seq_ctl_t;

endpackage

/* rtl/dcc_msg_store.sv */
// message byte store: register file with one write port and one read port
`timescale 1ns / 1ps

module dcc_msg_store
  import dcc_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic       clk,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  input  logic [3:0] rd_pos,
  output logic [7:0] rd_data
);

  localparam int IDX_W = $clog2(MSG_BYTES);

  logic [7:0] mem [MSG_BYTES];
  logic [CNT_W-1:0] wr_wide;
  logic [CNT_W-1:0] rd_wide;

  assign wr_wide = CNT_W'(wr_index);
  assign rd_wide = CNT_W'(rd_pos);

  // indexes past the depth are dropped on write and read as zero
  always_ff @(posedge clk) begin
    if (wr_en && (wr_wide < CNT_W'(MSG_BYTES))) begin
      mem[wr_wide[IDX_W-1:0]] <= wr_data;
    end
  end

  assign rd_data = (rd_wide < CNT_W'(MSG_BYTES)) ? mem[rd_wide[IDX_W-1:0]] : 8'd0;

endmodule

/* rtl/dcc_bit_seq.sv */
// bit sequencer: preamble, separators and byte bits, one half-bit per tick
`timescale 1ns / 1ps

module dcc_bit_seq
  import dcc_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  seq_ctl_t  ctl,
  input  logic [7:0] store_data,
  output logic [3:0] byte_pos,
  output out_item_t result
);

  logic       high_phase, high_phase_next;
  mode_t      mode, mode_next;
  logic [7:0] preamble_left, preamble_left_next;
  logic [7:0] extra_left, extra_left_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic [7:0] bit_mask, bit_mask_next;
  logic [3:0] byte_pos_next;
  logic [7:0] held_reload, held_reload_next;
  logic       held_one, held_one_next;
  logic [3:0] stored_length;
  logic [7:0] stored_preamble;

  logic           asked;
  logic [7:0]     pre_dec;
  logic [7:0]     ext_dec;
  logic [7:0]     mask_shr;
  logic           cur_one;
  logic [CNT_W-1:0] eff_len;
  logic [CNT_W-1:0] next_pos;

  // clamped message length: zero acts as one, capped at store depth
  always_comb begin
    if (stored_length == 4'd0) begin
      eff_len = CNT_W'(1);
    end else if (CNT_W'(stored_length) > CNT_W'(MSG_BYTES)) begin
      eff_len = CNT_W'(MSG_BYTES);
    end else begin
      eff_len = CNT_W'(stored_length);
    end
  end

  assign pre_dec = preamble_left - 8'd1;
  assign ext_dec = extra_left - 8'd1;
  assign mask_shr = bit_mask >> 1;
  assign cur_one = |(shift_byte & bit_mask);
  assign next_pos = CNT_W'(byte_pos) + CNT_W'(1);

  always_comb begin
    high_phase_next = high_phase;
    mode_next = mode;
    preamble_left_next = preamble_left;
    extra_left_next = extra_left;
    shift_byte_next = shift_byte;
    bit_mask_next = bit_mask;
    byte_pos_next = byte_pos;
    held_reload_next = held_reload;
    held_one_next = held_one;
    asked = 1'b0;
    if (ctl.tick && !high_phase) begin
      high_phase_next = 1'b1;
      unique case (mode)
        MODE_PRE: begin
          held_reload_next = cfg.short_reload;
          held_one_next = 1'b1;
          preamble_left_next = pre_dec;
          if (pre_dec == 8'd0) begin
            asked = 1'b1;
            if (ctl.msg_ready) begin
              byte_pos_next = 4'd0;
              if (stored_preamble > cfg.preamble_length) begin
                extra_left_next = stored_preamble - cfg.preamble_length;
                mode_next = MODE_EXT;
              end else begin
                mode_next = MODE_SEP;
              end
            end else begin
              preamble_left_next = 8'd1;
            end
          end
        end
        MODE_EXT: begin
          held_reload_next = cfg.short_reload;
          held_one_next = 1'b1;
          extra_left_next = ext_dec;
          if (ext_dec == 8'd0) begin
            mode_next = MODE_SEP;
          end
        end
        MODE_SEP: begin
          held_reload_next = cfg.long_reload;
          held_one_next = 1'b0;
          mode_next = MODE_BITS;
          bit_mask_next = FIRST_MASK;
          shift_byte_next = store_data;
        end
        MODE_BITS: begin
          held_one_next = cur_one;
          held_reload_next = cur_one ? cfg.short_reload : cfg.long_reload;
          bit_mask_next = mask_shr;
          if (mask_shr == 8'd0) begin
            if (next_pos >= eff_len) begin
              mode_next = MODE_PRE;
              preamble_left_next = cfg.preamble_length;
            end else begin
              mode_next = MODE_SEP;
            end
            byte_pos_next = next_pos[3:0];
          end
        end
        default: begin
          mode_next = MODE_PRE;
        end
      endcase
    end else if (ctl.tick) begin
      high_phase_next = 1'b0;
    end
    // preamble write reloads counter; user writes only if idle, unchecked
    if (cfg.preamble_wr) begin
      preamble_left_next = cfg.preamble_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_phase <= 1'b0;
      mode <= MODE_PRE;
      preamble_left <= PREAMBLE_RST;
      extra_left <= 8'd0;
      shift_byte <= 8'd0;
      bit_mask <= FIRST_MASK;
      byte_pos <= 4'd0;
      held_reload <= SHORT_RST;
      held_one <= 1'b1;
      stored_length <= 4'd0;
      stored_preamble <= 8'd0;
    end else begin
      high_phase <= high_phase_next;
      mode <= mode_next;
      preamble_left <= preamble_left_next;
      extra_left <= extra_left_next;
      shift_byte <= shift_byte_next;
      bit_mask <= bit_mask_next;
      byte_pos <= byte_pos_next;
      held_reload <= held_reload_next;
      held_one <= held_one_next;
      if (ctl.header_wr) begin
        stored_length <= ctl.msg_length;
        stored_preamble <= ctl.msg_preamble;
      end
    end
  end

  // second half repeats the held reload; first half shows the fresh one
  assign result.pin_level = high_phase;
  assign result.reload_value = high_phase ? held_reload : held_reload_next;
  assign result.bit_is_one = high_phase ? held_one : held_one_next;
  assign result.asked_message = asked;

endmodule

/* rtl/dcc_packet_waveform_generator.sv */
// top level: dcc track waveform generator with apb registers and item channels
`timescale 1ns / 1ps
//
// channel   direction  handshake                 payload
// in        to block   in_valid / in_stall       in_data  (in_item_t)
// out       from block out_valid / out_stall     out_data (out_item_t)
// apb       to block   psel / penable / pready   paddr, pwdata, prdata
//
// one item per clock while in_stall is low: an accepted item is held in the
// input register, then the sequencer updates its state and a tick loads the
// result register, so a tick's result passes the input register and then the
// result register before it is offered on the out side.
// writes (byte and header) give no result and never wait on the out side.
// a full result register that is stalled holds back only tick items.
// synchronous active-high reset; the message store has no reset.
//
module dcc_packet_waveform_generator
  import dcc_pkg::*;
#(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // item input
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [7:0] preamble_length;
  logic [7:0] long_reload;
  logic [7:0] short_reload;
  logic       cfg_wr;
  reg_idx_t   reg_idx;

  // input register
  logic     stage_valid;
  in_item_t stage;
  logic     stage_tick;
  logic     advance;
  logic     accept;

  cfg_t       cfg;
  seq_ctl_t   ctl;
  out_item_t  result;
  logic [3:0] byte_pos;
  logic [7:0] store_data;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      preamble_length <= PREAMBLE_RST;
      long_reload <= LONG_RST;
      short_reload <= SHORT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_PREAMBLE: preamble_length <= pwdata[7:0];
        REG_LONG:     long_reload <= pwdata[7:0];
        REG_SHORT:    short_reload <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_PREAMBLE: prdata = {24'd0, preamble_length};
      REG_LONG:     prdata = {24'd0, long_reload};
      REG_SHORT:    prdata = {24'd0, short_reload};
      default:      prdata = 32'd0;
    endcase
  end

  // a tick needs room in the result register; writes always move on
  assign stage_tick = (stage.opcode == OP_TICK);
  assign advance = stage_valid && (!stage_tick || !out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage <= in_data;
    end
  end

  assign cfg.preamble_length = preamble_length;
  assign cfg.long_reload = long_reload;
  assign cfg.short_reload = short_reload;
  assign cfg.preamble_wr = cfg_wr && (reg_idx == REG_PREAMBLE);
  // counter reload takes the value being written, not the old register
  assign cfg.preamble_wdata = pwdata[7:0];

  assign ctl.tick = advance && stage_tick;
  assign ctl.msg_ready = stage.msg_ready;
  assign ctl.header_wr = advance && (stage.opcode == OP_HEADER);
  assign ctl.msg_length = stage.msg_length;
  assign ctl.msg_preamble = stage.msg_preamble;

  dcc_msg_store #(
    .MSG_BYTES(MSG_BYTES)
  ) u_store (
    .clk      (clk),
    .wr_en    (advance && (stage.opcode == OP_BYTE)),
    .wr_index (stage.byte_index),
    .wr_data  (stage.byte_value),
    .rd_pos   (byte_pos),
    .rd_data  (store_data)
  );

  dcc_bit_seq #(
    .MSG_BYTES(MSG_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .ctl        (ctl),
    .store_data (store_data),
    .byte_pos   (byte_pos),
    .result     (result)
  );

  // result register: loads on each tick, drains when the far side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.tick) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.tick) begin
      out_data <= result;
    end
  end

endmodule
